/* src/pfpc_pkg.sv */
// Shared constants and types for the pedometer filter and peak counter.
package pfpc_pkg;

    localparam int MAG_WINDOW_DEF    = 30;
    localparam int DIFF_WINDOW_DEF   = 10;
    localparam int ENERGY_WINDOW_DEF = 5;

    localparam logic [31:0] THRESHOLD_RESET = 32'd167772;
    localparam int          ADDR_W          = 1;
    localparam logic [ADDR_W-1:0] REG_PEAK_THRESHOLD = 1'b0;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MAG,
        S_DIFF,
        S_SQUARE,
        S_ENERGY,
        S_EDIV,
        S_PEAK,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic mag;
        logic diff;
        logic square;
        logic energy;
        logic ediv;
        logic peak;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic mag_ready;
        logic diff_ready;
        logic energy_ready;
    } t_status;

endpackage

/* src/pfpc_if.sv */
// Valid/ready request channel carrying a payload.
interface pfpc_if #(parameter int W = 16) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/pfpc_ctrl.sv */
// Controller state machine sequencing one sample through the filter chain.
module pfpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_free,
    input  pfpc_pkg::t_status i_status,
    output logic              o_in_ready,
    output logic              o_out_load,
    output pfpc_pkg::t_cmd    o_cmd
);
    import pfpc_pkg::*;

    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_MAG;
            S_MAG:    n_state = (i_status.mag_ready) ? S_DIFF : S_OUT;
            S_DIFF:   n_state = (i_status.diff_ready) ? S_SQUARE : S_OUT;
            S_SQUARE: n_state = S_ENERGY;
            S_ENERGY: n_state = (i_status.energy_ready) ? S_EDIV : S_OUT;
            S_EDIV:   n_state = S_PEAK;
            S_PEAK:   n_state = S_OUT;
            S_OUT:    if (i_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE:   begin o_in_ready = 1'b1; o_cmd.load = i_in_valid; end
            S_MAG:    o_cmd.mag = 1'b1;
            S_DIFF:   o_cmd.diff = 1'b1;
            S_SQUARE: o_cmd.square = 1'b1;
            S_ENERGY: o_cmd.energy = 1'b1;
            S_EDIV:   o_cmd.ediv = 1'b1;
            S_PEAK:   o_cmd.peak = 1'b1;
            S_OUT:    o_out_load = i_out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

`ifndef NO_ASSERTIONS
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_mag_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.mag) else $error("mag step missing");
    a_square_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.square |=> o_cmd.energy) else $error("energy step missing");
`endif
endmodule

/* src/pfpc_dp.sv */
// Datapath: window shift lines, running sums, divider-free averages, square, peak test.
module pfpc_dp #(
    parameter int MAG_WINDOW    = pfpc_pkg::MAG_WINDOW_DEF,
    parameter int DIFF_WINDOW   = pfpc_pkg::DIFF_WINDOW_DEF,
    parameter int ENERGY_WINDOW = pfpc_pkg::ENERGY_WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfpc_pkg::t_cmd    i_cmd,
    input  logic [15:0]       i_magnitude,
    input  logic [31:0]       i_threshold,
    output pfpc_pkg::t_status o_status,
    output logic [15:0]       o_step_count,
    output logic              o_peak_found,
    output logic [31:0]       o_filtered_value,
    output logic              o_filtered_valid
);
    import pfpc_pkg::*;

    localparam int MSUM_W = 16 + $clog2(MAG_WINDOW + 1);
    localparam int DSUM_W = 17 + $clog2(DIFF_WINDOW + 1) + 1;
    localparam int ESUM_W = 32 + $clog2(ENERGY_WINDOW + 1);
    localparam int C0_W   = $clog2(MAG_WINDOW + 3);
    localparam int C1_W   = $clog2(DIFF_WINDOW + 2);
    localparam int C2_W   = $clog2(ENERGY_WINDOW + 2);
    // Reciprocal multiply: q = (x * RECIP) >> SH, corrected by one compare
    localparam int          MSH     = MSUM_W + 1;
    localparam logic [MSH:0] MRECIP = (MSH+1)'((64'd1 << MSH) / MAG_WINDOW);
    localparam int          DSH     = DSUM_W;
    localparam logic [DSH:0] DRECIP = (DSH+1)'((64'd1 << DSH) / DIFF_WINDOW);
    // Energy division works on 24-bit pieces: the upper bits first, then the
    // remainder joined with the lower ESPLIT bits
    localparam int             EDIV_W = 24;
    localparam int             ESPLIT = 18;
    localparam logic [EDIV_W:0] ERECIP = (EDIV_W+1)'((64'd1 << EDIV_W) / ENERGY_WINDOW);

    logic [15:0]       r_mwin [MAG_WINDOW];
    logic [MSUM_W-1:0] r_msum;
    logic [15:0]       r_prev;
    logic signed [16:0] r_dwin [DIFF_WINDOW];
    logic signed [DSUM_W-1:0] r_dsum;
    logic [31:0]       r_ewin [ENERGY_WINDOW];
    logic [ESUM_W-1:0] r_esum;
    logic [C0_W-1:0]   r_c0;
    logic [C1_W-1:0]   r_c1;
    logic [C2_W-1:0]   r_c2;
    logic [1:0]        r_c3;
    logic [31:0]       r_old, r_mid;
    logic [15:0]       r_total;
    logic [15:0]       r_sample;
    logic signed [16:0] r_diff;
    logic [16:0]       r_absavg;
    logic [31:0]       r_square;
    logic [EDIV_W-1:0] r_eqh, r_elo;
    logic [31:0]       r_filt;
    logic              r_fvalid, r_peak;

    // Floor division by ENERGY_WINDOW of a 24-bit value, gives {quotient, remainder}
    function automatic logic [2*EDIV_W-1:0] energy_div(input logic [EDIV_W-1:0] x);
        logic [2*EDIV_W+1:0] p;
        logic [EDIV_W-1:0]   q;
        logic [EDIV_W-1:0]   r;
        p = (2*EDIV_W+2)'(x) * (2*EDIV_W+2)'(ERECIP);
        q = EDIV_W'(p >> EDIV_W);
        r = x - EDIV_W'(q * EDIV_W'(ENERGY_WINDOW));
        if (r >= EDIV_W'(ENERGY_WINDOW)) begin
            q = q + 1'b1;
            r = r - EDIV_W'(ENERGY_WINDOW);
        end
        return {q, r};
    endfunction

    // Smoothed magnitude: floor(sum / MAG_WINDOW) of the updated sum
    logic [MSUM_W-1:0]       msum_new;
    logic [2*MSH+1:0]        mprod;
    logic [MSUM_W-1:0]       mq, mrem;
    logic [MSUM_W-1:0]       mquot;
    assign msum_new = r_msum - MSUM_W'(r_mwin[MAG_WINDOW-1]) + MSUM_W'(r_sample);
    assign mprod    = (2*MSH+2)'(msum_new) * (2*MSH+2)'(MRECIP);
    assign mq       = MSUM_W'(mprod >> MSH);
    assign mrem     = msum_new - MSUM_W'(mq * MSUM_W'(MAG_WINDOW));
    assign mquot    = (mrem >= MSUM_W'(MAG_WINDOW)) ? mq + 1'b1 : mq;

    // Difference average: floor division on signed sum via magnitude
    logic signed [16:0]       diff;
    logic signed [DSUM_W-1:0] dsum_new;
    logic [DSUM_W-1:0]        dabs, dnum, dq, drem, dquot;
    logic [2*DSH+1:0]         dprod;
    logic                     dneg;
    assign diff     = r_diff;
    assign dsum_new = r_dsum - DSUM_W'(r_dwin[DIFF_WINDOW-1]) + DSUM_W'(diff);
    assign dneg     = dsum_new[DSUM_W-1];
    assign dabs     = dneg ? DSUM_W'(-dsum_new) : DSUM_W'(dsum_new);
    // ceil for negatives: (|x| + d - 1) / d
    assign dnum     = dneg ? dabs + DSUM_W'(DIFF_WINDOW - 1) : dabs;
    assign dprod    = (2*DSH+2)'(dnum) * (2*DSH+2)'(DRECIP);
    assign dq       = DSUM_W'(dprod >> DSH);
    assign drem     = dnum - DSUM_W'(dq * DSUM_W'(DIFF_WINDOW));
    assign dquot    = (drem >= DSUM_W'(DIFF_WINDOW)) ? dq + 1'b1 : dq;

    // Energy average: running sum, then the division in two steps
    logic [ESUM_W-1:0]   esum_new;
    logic [EDIV_W-1:0]   ehi, elo_q;
    logic [2*EDIV_W-1:0] ehi_qr, elo_qr;
    logic [31:0]         efilt;
    assign esum_new = r_esum - ESUM_W'(r_ewin[ENERGY_WINDOW-1]) + ESUM_W'(r_square);
    assign ehi      = EDIV_W'(r_esum >> ESPLIT);
    assign ehi_qr   = energy_div(ehi);
    assign elo_qr   = energy_div(r_elo);
    assign elo_q    = elo_qr[2*EDIV_W-1:EDIV_W];
    assign efilt    = 32'({r_eqh, elo_q[ESPLIT-1:0]});

    assign o_status.mag_ready    = (r_c0 >= C0_W'(MAG_WINDOW + 1));
    assign o_status.diff_ready   = (r_c1 >= C1_W'(DIFF_WINDOW));
    assign o_status.energy_ready = (r_c2 >= C2_W'(ENERGY_WINDOW));

    // Control counters and accumulated state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0; r_c1 <= '0; r_c2 <= '0; r_c3 <= '0;
            r_msum <= '0; r_dsum <= '0; r_esum <= '0;
            r_prev <= '0; r_old <= '0; r_mid <= '0; r_total <= '0;
            r_fvalid <= 1'b0; r_peak <= 1'b0; r_filt <= '0;
            for (int k = 0; k < MAG_WINDOW; k++) r_mwin[k] <= '0;
            for (int k = 0; k < DIFF_WINDOW; k++) r_dwin[k] <= '0;
            for (int k = 0; k < ENERGY_WINDOW; k++) r_ewin[k] <= '0;
        end else begin
            if (i_cmd.load) begin
                r_fvalid <= 1'b0;
                r_peak   <= 1'b0;
                r_filt   <= '0;
            end
            // Stage 1: shift the sample in, form the smoothed value
            if (i_cmd.mag) begin
                r_msum <= msum_new;
                for (int k = MAG_WINDOW - 1; k > 0; k--) r_mwin[k] <= r_mwin[k-1];
                r_mwin[0] <= r_sample;
                if (r_c0 < C0_W'(MAG_WINDOW + 2)) r_c0 <= r_c0 + 1'b1;
                if (r_c0 >= C0_W'(MAG_WINDOW)) r_prev <= 16'(mquot);
            end
            // Stage 2 and 3: difference and its average
            if (i_cmd.diff) begin
                r_dsum <= dsum_new;
                for (int k = DIFF_WINDOW - 1; k > 0; k--) r_dwin[k] <= r_dwin[k-1];
                r_dwin[0] <= diff;
                if (r_c1 < C1_W'(DIFF_WINDOW + 1)) r_c1 <= r_c1 + 1'b1;
            end
            // Stage 5: energy sum
            if (i_cmd.energy) begin
                r_esum <= esum_new;
                for (int k = ENERGY_WINDOW - 1; k > 0; k--) r_ewin[k] <= r_ewin[k-1];
                r_ewin[0] <= r_square;
                if (r_c2 < C2_W'(ENERGY_WINDOW + 1)) r_c2 <= r_c2 + 1'b1;
            end
            // Take the filtered value and test the middle value for a peak
            if (i_cmd.peak) begin
                r_filt   <= efilt;
                r_fvalid <= 1'b1;
                if (r_c3 == 2'd2) begin
                    if (r_mid > r_old && r_mid > efilt && r_mid > i_threshold) begin
                        r_peak <= 1'b1;
                        if (r_total != 16'hFFFF) r_total <= r_total + 1'b1;
                    end
                end else begin
                    r_c3 <= r_c3 + 1'b1;
                end
                r_old <= r_mid;
                r_mid <= efilt;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_sample <= i_magnitude;
        if (i_cmd.mag) r_diff <= $signed({1'b0, mquot[15:0]}) - $signed({1'b0, r_prev});
        if (i_cmd.diff) r_absavg <= 17'(dquot);
        if (i_cmd.square) r_square <= 32'(r_absavg) * 32'(r_absavg);
        if (i_cmd.ediv) begin
            r_eqh <= ehi_qr[2*EDIV_W-1:EDIV_W];
            r_elo <= EDIV_W'({ehi_qr[EDIV_W-1:0], r_esum[ESPLIT-1:0]});
        end
    end

    assign o_step_count     = r_total;
    assign o_peak_found     = r_peak;
    assign o_filtered_value = r_filt;
    assign o_filtered_valid = r_fvalid;

`ifndef NO_ASSERTIONS
    a_peak_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak |-> r_fvalid) else $error("peak without filtered value");
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total >= $past(r_total) || $past(!i_rst_n)) else $error("count fell");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c3 <= 2'd2) else $error("peak fill count overrun");
`endif
endmodule

/* src/pedometer_filter_peak_counter.sv */
// Top level: pedometer filter chain and saturating peak counter.
// One sample is taken in the idle state; the controller then walks a single
// shared datapath through the average, difference, square, energy, divide and
// peak steps, stops early while the windows are still filling, and holds the
// result while the output register is still full. The input is ready only in
// the idle state, in the cycle after the previous result has moved to the
// output register, so a new sample is not taken before the last one is through.
// The peak threshold is written over the APB port at byte address 0.
module pedometer_filter_peak_counter #(
    parameter int MAG_WINDOW    = pfpc_pkg::MAG_WINDOW_DEF,
    parameter int DIFF_WINDOW   = pfpc_pkg::DIFF_WINDOW_DEF,
    parameter int ENERGY_WINDOW = pfpc_pkg::ENERGY_WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pfpc_if.sink                        in_ch,
    pfpc_if.source                      out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfpc_pkg::ADDR_W+1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pfpc_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic        out_load, out_free;
    logic [31:0] r_threshold;
    logic        r_ovalid;
    logic [49:0] r_odata;
    logic [15:0] step_count;
    logic        peak_found, filtered_valid;
    logic [31:0] filtered_value;
    logic        addr_hit;

    assign pready   = 1'b1;
    assign addr_hit = (paddr == {REG_PEAK_THRESHOLD, 2'b00});
    assign prdata   = addr_hit ? r_threshold : '0;

    // Register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_threshold <= THRESHOLD_RESET;
        else if (psel && penable && pwrite && addr_hit) r_threshold <= pwdata;
    end

    pfpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (in_ch.ready),
        .o_out_load (out_load),
        .o_cmd      (cmd)
    );

    pfpc_dp #(
        .MAG_WINDOW    (MAG_WINDOW),
        .DIFF_WINDOW   (DIFF_WINDOW),
        .ENERGY_WINDOW (ENERGY_WINDOW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_magnitude      (in_ch.data),
        .i_threshold      (r_threshold),
        .o_status         (status),
        .o_step_count     (step_count),
        .o_peak_found     (peak_found),
        .o_filtered_value (filtered_value),
        .o_filtered_valid (filtered_valid)
    );

    // Output register: hold the result until the request is taken
    assign out_free = !r_ovalid || out_ch.ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (out_load) r_ovalid <= 1'b1;
        else if (out_ch.ready) r_ovalid <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (out_load) r_odata <= {filtered_valid, filtered_value, peak_found, step_count};
    end
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_odata;

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("output request dropped");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free) else $error("result overwritten");
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && addr_hit |=> r_threshold == $past(pwdata))
        else $error("threshold not written");
`endif
endmodule

/* test/tb_top.sv */
// Self-checking testbench for the pedometer filter and peak counter.
`timescale 1ns / 100ps

module tb_top;
    import pfpc_pkg::*;

    localparam int MAG_LEN    = MAG_WINDOW_DEF;
    localparam int DIFF_LEN   = DIFF_WINDOW_DEF;
    localparam int ENERGY_LEN = ENERGY_WINDOW_DEF;
    localparam int RES_W      = 50;
    localparam int SETTLE     = 12;

    typedef struct packed {
        logic        filtered_valid;
        logic [31:0] filtered_value;
        logic        peak_found;
        logic [15:0] step_count;
    } t_step_result;

    typedef struct {
        logic [15:0]  magnitude;
        bit           typed;
        t_step_result want;
    } t_sample_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W+1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    pfpc_if #(.W(16)) in_if (i_clk);
    pfpc_if #(.W(RES_W)) out_if (i_clk);

    pedometer_filter_peak_counter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock: 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state
    logic [31:0]        thresh_q;
    logic [15:0]        mag_win [MAG_LEN];
    logic [20:0]        mag_sum;
    logic [15:0]        prev_smooth;
    logic signed [16:0] diff_win [DIFF_LEN];
    logic signed [20:0] diff_sum;
    logic [31:0]        energy_win [ENERGY_LEN];
    logic [34:0]        energy_sum;
    int                 fill_mag, fill_diff, fill_energy, fill_filt;
    logic [31:0]        filt_older, filt_newer;
    logic [15:0]        steps;

    t_step_result expected_steps[$];
    int  mismatches = 0;
    int  send_idle = 0;
    int  recv_idle = 0;
    int  hold_cycles = 0;

    // Clear the filter chain, the step count and the threshold copy
    function automatic void clear_filter();
        foreach (mag_win[i]) mag_win[i] = '0;
        foreach (diff_win[i]) diff_win[i] = '0;
        foreach (energy_win[i]) energy_win[i] = '0;
        mag_sum = '0; prev_smooth = '0; diff_sum = '0; energy_sum = '0;
        fill_mag = 0; fill_diff = 0; fill_energy = 0; fill_filt = 0;
        filt_older = '0; filt_newer = '0; steps = '0;
        thresh_q = THRESHOLD_RESET;
    endfunction

    // Advance the filter chain by one sample and return the result it gives
    function automatic t_step_result filter_sample(logic [15:0] mag);
        t_step_result r;
        logic [15:0] smooth;
        logic signed [16:0] d;
        longint q;
        longint a;
        logic [31:0] sq;
        logic [31:0] filt;
        bit fv;
        r = '0;
        fv = 0;
        filt = '0;
        mag_sum = mag_sum - mag_win[MAG_LEN-1] + mag;
        for (int i = MAG_LEN - 1; i > 0; i--) mag_win[i] = mag_win[i-1];
        mag_win[0] = mag;
        if (fill_mag < MAG_LEN + 2) fill_mag++;
        if (fill_mag >= MAG_LEN + 1) begin
            smooth = 16'(mag_sum / MAG_LEN);
            if (fill_mag > MAG_LEN + 1) begin
                d = $signed({1'b0, smooth}) - $signed({1'b0, prev_smooth});
                diff_sum = diff_sum - diff_win[DIFF_LEN-1] + d;
                for (int i = DIFF_LEN - 1; i > 0; i--) diff_win[i] = diff_win[i-1];
                diff_win[0] = d;
                if (fill_diff < DIFF_LEN + 1) fill_diff++;
                if (fill_diff >= DIFF_LEN + 1) begin
                    // round toward minus infinity
                    q = longint'(diff_sum) / DIFF_LEN;
                    if (diff_sum < 0 && (longint'(diff_sum) % DIFF_LEN) != 0) q = q - 1;
                    a = (q < 0) ? -q : q;
                    sq = 32'(a * a);
                    energy_sum = energy_sum - energy_win[ENERGY_LEN-1] + sq;
                    for (int i = ENERGY_LEN - 1; i > 0; i--) energy_win[i] = energy_win[i-1];
                    energy_win[0] = sq;
                    if (fill_energy < ENERGY_LEN + 1) fill_energy++;
                    if (fill_energy >= ENERGY_LEN + 1) begin
                        filt = 32'(energy_sum / ENERGY_LEN);
                        fv = 1;
                    end
                end
            end
            prev_smooth = smooth;
        end
        if (fv) begin
            if (fill_filt >= 2) begin
                if (filt_newer > filt_older && filt_newer > filt && filt_newer > thresh_q) begin
                    r.peak_found = 1'b1;
                    if (steps != 16'hFFFF) steps++;
                end
            end else begin
                fill_filt++;
            end
            filt_older = filt_newer;
            filt_newer = filt;
        end
        r.step_count = steps;
        r.filtered_value = fv ? filt : 32'd0;
        r.filtered_valid = fv;
        return r;
    endfunction

    // Hold the request until accepted, then predict its result
    task automatic send_sample(logic [15:0] mag, bit typed, t_step_result want);
        t_step_result got;
        while ($urandom_range(99) < send_idle) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.data  <= mag;
        do @(posedge i_clk); while (!in_if.ready);
        got = filter_sample(mag);
        expected_steps.insert(expected_steps.size(), typed ? want : got);
    endtask

    // Write one register across setup and access cycles
    task automatic write_reg(logic [ADDR_W+1:0] addr, logic [31:0] value);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == {REG_PEAK_THRESHOLD, 2'b00}) thresh_q = value;
    endtask

    // Drain outstanding results, then let the datapath settle
    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Walking-like waveform with random stride period and strength, and random spikes
    task automatic send_walk(int count);
        int period, amp, base, ph, tri_v, v;
        period = $urandom_range(100, 30);
        amp = $urandom_range(6000);
        base = $urandom_range(8000, 2000);
        for (int n = 0; n < count; n++) begin
            if (n % 120 == 119) begin
                period = $urandom_range(100, 30);
                amp = ($urandom_range(9) == 0) ? 0 : $urandom_range(6000);
            end
            if ($urandom_range(99) < 12) begin
                v = $urandom_range(65535);
            end else begin
                ph = n % period;
                tri_v = (ph < period / 2) ? ph : period - ph;
                v = base + (amp * tri_v * 2) / period + $urandom_range(63);
                if (v > 65535) v = 65535;
            end
            send_sample(16'(v), 0, '0);
        end
    endtask

    // Receiver: pick ready each cycle, honour the long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_step_result got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (expected_steps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_steps.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        t_sample_row rows[$];
        t_sample_row row;
        logic [31:0] thresholds[4];
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        clear_filter();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes during warm-up, where no filtered value exists yet
        for (int i = 0; i < 24; i++) begin
            row.magnitude = (i % 4 == 1) ? 16'hFFFF : (i % 4 == 3) ? 16'h5555 :
                            (i % 4 == 2) ? 16'hAAAA : 16'h0000;
            row.typed = 1;
            row.want = '0;
            rows.insert(rows.size(), row);
        end
        send_idle = 20; recv_idle = 57;
        foreach (rows[i]) send_sample(rows[i].magnitude, rows[i].typed, rows[i].want);
        drain();

        // Phases: default, zero, largest, moderate threshold
        thresholds[0] = THRESHOLD_RESET;
        thresholds[1] = 32'd0;
        thresholds[2] = 32'hFFFF_FFFF;
        thresholds[3] = $urandom_range(2000000);
        for (int p = 0; p < 4; p++) begin
            write_reg({REG_PEAK_THRESHOLD, 2'b00}, thresholds[p]);
            write_reg(3'b100, $urandom);
            send_idle = (p == 1) ? 57 : (p == 0) ? 20 : 0;
            recv_idle = (p == 1) ? 20 : (p == 0) ? 57 : 0;
            if (p == 2) hold_cycles = 300;
            send_walk(250);
            drain();
        end

        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

/* files.f */
src/pfpc_pkg.sv
src/pfpc_if.sv
src/pfpc_ctrl.sv
src/pfpc_dp.sv
src/pedometer_filter_peak_counter.sv
test/tb_top.sv
